>>> rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helper functions of the lenient UTF-8 stream
// decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   // Result slots per request; a truncated run gives at most three results.
   localparam int MaxResults = 4;

   typedef logic [7:0]  byte_type;
   typedef logic [20:0] cp_type;
   typedef logic [2:0]  len_type;

   // Lead byte classification masks and patterns
   localparam byte_type AsciiMask  = 8'h80;
   localparam byte_type Lead2Mask  = 8'hE0;
   localparam byte_type Lead2Match = 8'hC0;
   localparam byte_type Lead3Mask  = 8'hF0;
   localparam byte_type Lead3Match = 8'hE0;
   localparam byte_type Lead4Mask  = 8'hF8;
   localparam byte_type Lead4Match = 8'hF0;

   localparam len_type LenNone = 3'd0;
   localparam len_type LenOne  = 3'd1;
   localparam len_type LenTwo  = 3'd2;
   localparam len_type LenThree = 3'd3;
   localparam len_type LenFour = 3'd4;

   // Group of results produced by one request, oldest in slot 0
   typedef struct packed {
      len_type           count;
      logic              last;
      cp_type [MaxResults-1:0] cp;
   } bundle_type;

   // Decoder state seen from the top level
   typedef struct packed {
      len_type    seq_len;
      logic [1:0] held_count;
   } dec_status_type;

   // Sequence length a lead byte announces; LenNone if not a multi-byte lead
   function automatic len_type lead_length(input byte_type b);
      len_type n;
      priority if ((b & Lead2Mask) == Lead2Match) n = LenTwo;
      else if ((b & Lead3Mask) == Lead3Match) n = LenThree;
      else if ((b & Lead4Mask) == Lead4Match) n = LenFour;
      else n = LenNone;
      return n;
   endfunction

endpackage

>>> rtl/utf8d_req_if.sv
// ----------------------------------------------------------------------------
// utf8d_req_if
// Request channel: one raw byte of a text run with its end-of-run flag.
// ----------------------------------------------------------------------------
interface utf8d_req_if;
   logic                valid;
   logic                ready;
   utf8d_pkg::byte_type data_byte;
   logic                run_end;

   modport source (output valid, output data_byte, output run_end, input ready);
   modport sink   (input valid, input data_byte, input run_end, output ready);
endinterface

>>> rtl/utf8d_rsp_if.sv
// ----------------------------------------------------------------------------
// utf8d_rsp_if
// Response channel: one decoded code point with its last-of-run flag.
// ----------------------------------------------------------------------------
interface utf8d_rsp_if;
   logic              valid;
   logic              ready;
   utf8d_pkg::cp_type code_point;
   logic              run_last;

   modport source (output valid, output code_point, output run_last, input ready);
   modport sink   (input valid, input code_point, input run_last, output ready);
endinterface

>>> rtl/lenient_utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// lenient_utf8_stream_decoder_top
// Lenient streaming UTF-8 decoder: raw bytes in, code points out.
//
//   channel   dir  payload                          handshake
//   req_chan  in   data_byte[7:0], run_end          valid/ready
//   rsp_chan  out  code_point[20:0], run_last       valid/ready
//
// One request is taken per cycle while the result group register can load; the
// code point of a multi-byte sequence is loaded into the result group register
// as its last byte is taken. A run end with a short sequence open gives up to
// three code points, sent one per cycle from that register unless the output
// register stalls; req_chan.ready is low until the last of them leaves.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled rsp_chan fills the output register, then the group register.
// ----------------------------------------------------------------------------
module lenient_utf8_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   utf8d_req_if.sink   req_chan,
   utf8d_rsp_if.source rsp_chan
);

   utf8d_pkg::bundle_type     bundle;
   logic                      bundle_load;
   utf8d_pkg::dec_status_type dec_status;
   logic                      accept;
   logic                      burst_ready;
   logic                      mid_valid;
   utf8d_pkg::cp_type         mid_cp;
   logic                      mid_last;
   logic                      mid_ready;
   utf8d_pkg::len_type        pending;

   assign req_chan.ready = burst_ready;
   assign accept         = req_chan.valid && burst_ready;

   utf8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_chan.data_byte),
      .run_end    (req_chan.run_end),
      .bundle     (bundle),
      .bundle_load(bundle_load),
      .status     (dec_status)
   );

   utf8d_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .load       (bundle_load),
      .load_ready (burst_ready),
      .down_valid (mid_valid),
      .down_cp    (mid_cp),
      .down_last  (mid_last),
      .down_ready (mid_ready),
      .pending    (pending)
   );

   utf8d_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mid_valid),
      .up_cp    (mid_cp),
      .up_last  (mid_last),
      .up_ready (mid_ready),
      .rsp_chan (rsp_chan)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // a run end closes any open sequence and leaves results to send
   a_run_end_closes: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.run_end |=>
         dec_status.seq_len == utf8d_pkg::LenNone && dec_status.held_count == 2'd0
         && pending != '0)
      else $error("run end did not close the sequence");

   // held bytes always stay below the announced sequence length
   a_held_below_len: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, dec_status.held_count} < dec_status.seq_len)
      || (dec_status.seq_len == utf8d_pkg::LenNone && dec_status.held_count == 2'd0))
      else $error("held byte count out of step with sequence length");

   // the group register never holds more than a full group
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= utf8d_pkg::len_type'(utf8d_pkg::MaxResults))
      else $error("result group overflow");

   // a new group is only loaded into a free group register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      bundle_load |-> burst_ready && bundle.count != '0)
      else $error("result group loaded while busy or empty");

endmodule

>>> rtl/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and single-pass decode. Holds the bytes of an open sequence
// and, per accepted request, builds the group of code points it produces.
// ----------------------------------------------------------------------------
module utf8d_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  utf8d_pkg::byte_type        data_byte,
   input  logic                       run_end,
   output utf8d_pkg::bundle_type      bundle,
   output logic                       bundle_load,
   output utf8d_pkg::dec_status_type  status
);

   utf8d_pkg::byte_type held_ff [3];
   logic [1:0]          count_ff, count_in;
   utf8d_pkg::len_type  seq_ff, seq_in;
   logic                hold_we;

   utf8d_pkg::byte_type seq_bytes [7];
   utf8d_pkg::len_type  len;
   utf8d_pkg::cp_type   cp_at   [utf8d_pkg::MaxResults];
   utf8d_pkg::len_type  used_at [utf8d_pkg::MaxResults];
   utf8d_pkg::len_type  pos     [utf8d_pkg::MaxResults+1];
   utf8d_pkg::len_type  chain_count;
   utf8d_pkg::len_type  new_lead;

   // Byte window: held bytes, then the new byte, zero past the end
   always_comb begin
      len = {1'b0, count_ff} + utf8d_pkg::LenOne;
      for (int i = 0; i < 7; i++) seq_bytes[i] = '0;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < count_ff) seq_bytes[i] = held_ff[i];
      end
      seq_bytes[{1'b0, count_ff}] = data_byte;
   end

   // Decode candidate at each start position
   always_comb begin
      utf8d_pkg::byte_type first;
      utf8d_pkg::len_type  rem;
      utf8d_pkg::len_type  lead;
      for (int p = 0; p < utf8d_pkg::MaxResults; p++) begin
         first = seq_bytes[p];
         rem   = len - 3'(p);
         lead  = utf8d_pkg::lead_length(first);
         if ((first & utf8d_pkg::AsciiMask) == '0) begin
            cp_at[p]   = {13'b0, first};
            used_at[p] = utf8d_pkg::LenOne;
         end else if (lead == utf8d_pkg::LenNone || lead > rem) begin
            // stray or truncated lead
            cp_at[p]   = '0;
            used_at[p] = utf8d_pkg::LenOne;
         end else begin
            used_at[p] = lead;
            unique case (lead)
               utf8d_pkg::LenTwo: begin
                  cp_at[p] = {10'b0, first[4:0], seq_bytes[p+1][5:0]};
               end
               utf8d_pkg::LenThree: begin
                  cp_at[p] = {5'b0, first[3:0], seq_bytes[p+1][5:0],
                              seq_bytes[p+2][5:0]};
               end
               default: begin
                  cp_at[p] = {first[2:0], seq_bytes[p+1][5:0],
                              seq_bytes[p+2][5:0], seq_bytes[p+3][5:0]};
               end
            endcase
         end
      end
   end

   // Walk the window: each result starts where the previous one stopped
   always_comb begin
      pos[0]      = '0;
      chain_count = '0;
      for (int k = 0; k < utf8d_pkg::MaxResults; k++) begin
         if (pos[k] < len) begin
            bundle.cp[k] = cp_at[pos[k][1:0]];
            pos[k+1]     = pos[k] + used_at[pos[k][1:0]];
            chain_count  = 3'(k + 1);
         end else begin
            bundle.cp[k] = '0;
            pos[k+1]     = pos[k];
         end
      end
      bundle.count = run_end ? chain_count : utf8d_pkg::LenOne;
      bundle.last  = run_end;
   end

   // Next state of the open sequence
   always_comb begin
      new_lead    = utf8d_pkg::lead_length(data_byte);
      count_in    = count_ff;
      seq_in      = seq_ff;
      hold_we     = 1'b0;
      bundle_load = 1'b0;
      if (accept) begin
         priority if (run_end) begin
            bundle_load = 1'b1;
            count_in    = '0;
            seq_in      = utf8d_pkg::LenNone;
         end else if (seq_ff == utf8d_pkg::LenNone) begin
            if (new_lead != utf8d_pkg::LenNone) begin
               hold_we  = 1'b1;
               count_in = 2'd1;
               seq_in   = new_lead;
            end else begin
               bundle_load = 1'b1;
            end
         end else if (len >= seq_ff) begin
            bundle_load = 1'b1;
            count_in    = '0;
            seq_in      = utf8d_pkg::LenNone;
         end else begin
            hold_we  = 1'b1;
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seq_ff   <= utf8d_pkg::LenNone;
      end else begin
         count_ff <= count_in;
         seq_ff   <= seq_in;
      end
   end

   // held bytes: payload only
   always_ff @(posedge clock) begin
      if (hold_we) held_ff[count_ff] <= data_byte;
   end

   assign status.seq_len    = seq_ff;
   assign status.held_count = count_ff;

endmodule

>>> rtl/utf8d_burst.sv
// ----------------------------------------------------------------------------
// utf8d_burst
// Result group register. Loads the code points of one request and hands
// them on one per cycle when down_ready allows, flagging the last one of a run.
// ----------------------------------------------------------------------------
module utf8d_burst (
   input  logic                  clock,
   input  logic                  reset,
   input  utf8d_pkg::bundle_type bundle,
   input  logic                  load,
   output logic                  load_ready,
   output logic                  down_valid,
   output utf8d_pkg::cp_type     down_cp,
   output logic                  down_last,
   input  logic                  down_ready,
   output utf8d_pkg::len_type    pending
);

   utf8d_pkg::cp_type  cp_ff [utf8d_pkg::MaxResults];
   utf8d_pkg::cp_type  cp_in [utf8d_pkg::MaxResults];
   utf8d_pkg::len_type rem_ff, rem_in;
   logic               last_ff, last_in;
   logic               pop;

   assign down_valid = rem_ff != '0;
   assign pop        = down_valid && down_ready;
   // free once the last waiting result leaves
   assign load_ready = rem_ff == '0 || (rem_ff == utf8d_pkg::LenOne && pop);
   assign down_cp    = cp_ff[0];
   assign down_last  = last_ff && rem_ff == utf8d_pkg::LenOne;
   assign pending    = rem_ff;

   // Load a new group or shift the current one down
   always_comb begin
      rem_in  = rem_ff;
      last_in = last_ff;
      for (int k = 0; k < utf8d_pkg::MaxResults; k++) cp_in[k] = cp_ff[k];
      priority if (load) begin
         rem_in  = bundle.count;
         last_in = bundle.last;
         for (int k = 0; k < utf8d_pkg::MaxResults; k++) cp_in[k] = bundle.cp[k];
      end else if (pop) begin
         rem_in = rem_ff - utf8d_pkg::LenOne;
         for (int k = 0; k < utf8d_pkg::MaxResults - 1; k++) cp_in[k] = cp_ff[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         last_ff <= 1'b0;
      end else begin
         rem_ff  <= rem_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < utf8d_pkg::MaxResults; k++) cp_ff[k] <= cp_in[k];
   end

endmodule

>>> rtl/utf8d_out_reg.sv
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Output register on the response channel; the response ready still reaches
// the result group register combinationally while this register is full.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  utf8d_pkg::cp_type up_cp,
   input  logic              up_last,
   output logic              up_ready,
   utf8d_rsp_if.source       rsp_chan
);

   logic              valid_ff, valid_in;
   utf8d_pkg::cp_type cp_ff;
   logic              last_ff;

   assign up_ready = !valid_ff || rsp_chan.ready;
   assign valid_in = up_valid || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         cp_ff   <= up_cp;
         last_ff <= up_last;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.code_point = cp_ff;
   assign rsp_chan.run_last   = last_ff;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lenient UTF-8 stream decoder. A directed set of
// byte runs covers ASCII limits, stray and invalid bytes, complete 2/3/4-byte
// sequences and runs cut short inside a sequence. Random runs of mostly
// well-formed characters with some noise follow. Every accepted request is
// fed to an in-bench decoder whose code points are checked in order against
// the response channel, under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomBytes = 223;
   localparam int unsigned IdlePercent = 29;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DrainCycles = 20;
   // Long output hold-off, started once enough requests have gone in
   localparam int unsigned HoldoffStart = 120;
   localparam int unsigned HoldoffCycles = 80;
   // Request counts between which neither side idles
   localparam int unsigned QuietFrom = 170;
   localparam int unsigned QuietTo   = 230;

   typedef struct packed {
      utf8d_pkg::byte_type data_byte;
      logic                run_end;
   } text_byte_type;

   typedef struct packed {
      utf8d_pkg::cp_type code_point;
      logic              run_last;
   } code_point_item_type;

   logic clock;
   logic reset;

   utf8d_req_if req_chan ();
   utf8d_rsp_if rsp_chan ();

   lenient_utf8_stream_decoder_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   text_byte_type       byte_queue [$];
   code_point_item_type pending_code_points [$];
   code_point_item_type oldest;

   // Decoder state mirrored by the bench
   utf8d_pkg::byte_type held_bytes [3];
   logic [1:0]          held_count = 2'd0;
   utf8d_pkg::len_type  open_length = utf8d_pkg::LenNone;

   int unsigned requests_taken = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned holdoff_left = 0;
   bit          holdoff_done = 1'b0;
   bit          req_fired = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Reset
   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Sequence length announced by a lead byte, LenNone for anything else
   function automatic utf8d_pkg::len_type sequence_size(input utf8d_pkg::byte_type b);
      casez (b)
         8'b110?????: return utf8d_pkg::LenTwo;
         8'b1110????: return utf8d_pkg::LenThree;
         8'b11110???: return utf8d_pkg::LenFour;
         default:     return utf8d_pkg::LenNone;
      endcase
   endfunction

   // One code point from seq[pos..len-1]; returns the bytes it consumes
   function automatic int unsigned decode_at_pos(input utf8d_pkg::byte_type seq [4],
                                                 input int unsigned len,
                                                 input int unsigned pos,
                                                 output utf8d_pkg::cp_type cp);
      utf8d_pkg::byte_type lead;
      utf8d_pkg::len_type  n;
      lead = seq[pos];
      n = sequence_size(lead);
      cp = '0;
      if (lead[7] == 1'b0) begin
         cp = utf8d_pkg::cp_type'(lead);
         return 1;
      end
      // stray, invalid or truncated lead
      if (n == utf8d_pkg::LenNone || int'(n) > len - pos) return 1;
      case (n)
         utf8d_pkg::LenTwo:
            cp = utf8d_pkg::cp_type'({lead[4:0], seq[pos+1][5:0]});
         utf8d_pkg::LenThree:
            cp = utf8d_pkg::cp_type'({lead[3:0], seq[pos+1][5:0], seq[pos+2][5:0]});
         default:
            cp = utf8d_pkg::cp_type'({lead[2:0], seq[pos+1][5:0], seq[pos+2][5:0],
                                      seq[pos+3][5:0]});
      endcase
      return int'(n);
   endfunction

   // Append one expected code point
   task automatic expect_code_point(input utf8d_pkg::cp_type cp, input logic last);
      pending_code_points.insert(pending_code_points.size(),
                                 code_point_item_type'{code_point: cp, run_last: last});
   endtask

   // Expected code points for one accepted request
   task automatic decode_request(input text_byte_type item);
      utf8d_pkg::byte_type seq [4];
      int unsigned         len;
      int unsigned         pos;
      int unsigned         produced;
      utf8d_pkg::cp_type   cp;
      utf8d_pkg::len_type  n;
      logic                last;
      len = 0;
      for (int i = 0; i < int'(held_count); i++) begin
         seq[len] = held_bytes[i];
         len++;
      end
      seq[len] = item.data_byte;
      len++;
      if (!item.run_end) begin
         if (open_length == utf8d_pkg::LenNone) begin
            n = sequence_size(item.data_byte);
            if (n != utf8d_pkg::LenNone) begin
               held_bytes[0] = item.data_byte;
               held_count = 2'd1;
               open_length = n;
            end else begin
               void'(decode_at_pos(seq, len, 0, cp));
               expect_code_point(cp, 1'b0);
            end
         end else if (len >= int'(open_length)) begin
            void'(decode_at_pos(seq, len, 0, cp));
            expect_code_point(cp, 1'b0);
            held_count = 2'd0;
            open_length = utf8d_pkg::LenNone;
         end else begin
            held_bytes[held_count] = item.data_byte;
            held_count = held_count + 2'd1;
         end
      end else begin
         // run end: flush everything held, restarting after a short lead
         pos = 0;
         produced = 0;
         while (pos < len && produced < utf8d_pkg::MaxResults) begin
            pos += decode_at_pos(seq, len, pos, cp);
            produced++;
            last = (pos >= len) || (produced == utf8d_pkg::MaxResults);
            expect_code_point(cp, last);
         end
         held_count = 2'd0;
         open_length = utf8d_pkg::LenNone;
      end
   endtask

   task automatic push_byte(input utf8d_pkg::byte_type b, input logic ends);
      byte_queue.insert(byte_queue.size(), text_byte_type'{data_byte: b, run_end: ends});
   endtask

   function automatic utf8d_pkg::byte_type continuation_byte();
      // mostly 10xxxxxx, sometimes anything
      if ($urandom_range(0, 9) == 0) return utf8d_pkg::byte_type'($urandom_range(0, 255));
      return utf8d_pkg::byte_type'(8'h80 | $urandom_range(0, 63));
   endfunction

   // One random character; the run ends on its last byte when asked
   task automatic add_character(input logic ends_run);
      utf8d_pkg::byte_type seq [4];
      int unsigned         kind;
      int unsigned         width;
      int unsigned         n;
      kind = $urandom_range(0, 99);
      n = 1;
      if (kind < 30) begin
         seq[0] = utf8d_pkg::byte_type'($urandom_range(0, 127));
      end else if (kind < 48) begin
         seq[0] = utf8d_pkg::byte_type'(8'hC0 | $urandom_range(0, 31));
         n = 2;
      end else if (kind < 64) begin
         seq[0] = utf8d_pkg::byte_type'(8'hE0 | $urandom_range(0, 15));
         n = 3;
      end else if (kind < 78) begin
         seq[0] = utf8d_pkg::byte_type'(8'hF0 | $urandom_range(0, 7));
         n = 4;
      end else if (kind < 84) begin
         seq[0] = utf8d_pkg::byte_type'($urandom_range(8'h80, 8'hBF));
      end else if (kind < 89) begin
         seq[0] = utf8d_pkg::byte_type'($urandom_range(8'hF8, 8'hFF));
      end else begin
         // sequence missing its tail
         width = $urandom_range(2, 4);
         case (width)
            2:       seq[0] = utf8d_pkg::byte_type'(8'hC0 | $urandom_range(0, 31));
            3:       seq[0] = utf8d_pkg::byte_type'(8'hE0 | $urandom_range(0, 15));
            default: seq[0] = utf8d_pkg::byte_type'(8'hF0 | $urandom_range(0, 7));
         endcase
         n = $urandom_range(1, width - 1);
      end
      for (int unsigned i = 1; i < n; i++) seq[i] = continuation_byte();
      for (int unsigned i = 0; i < n; i++) push_byte(seq[i], ends_run && (i == n - 1));
   endtask

   task automatic add_run();
      int unsigned chars;
      if ($urandom_range(0, 9) == 0) begin
         // noise: random bytes with a random end flag
         chars = $urandom_range(1, 5);
         for (int unsigned i = 0; i < chars; i++)
            push_byte(utf8d_pkg::byte_type'($urandom_range(0, 255)),
                      $urandom_range(0, 5) == 0);
      end else begin
         chars = $urandom_range(1, 6);
         for (int unsigned i = 0; i < chars; i++) add_character(i == chars - 1);
      end
   endtask

   // Stimulus and end of test
   initial begin
      int unsigned target;
      // ASCII limits and stray bytes
      push_byte(8'h00, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hF8, 1'b0);
      push_byte(8'hFF, 1'b0);
      // complete 2-, 3- and 4-byte sequences
      push_byte(8'hC2, 1'b0);
      push_byte(8'hA9, 1'b0);
      push_byte(8'hE2, 1'b0);
      push_byte(8'h82, 1'b0);
      push_byte(8'hAC, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h9F, 1'b0);
      push_byte(8'h98, 1'b0);
      push_byte(8'h80, 1'b0);
      // continuation byte that is not 10xxxxxx
      push_byte(8'hC3, 1'b0);
      push_byte(8'h41, 1'b0);
      // run cut short; a shorter sequence completes in the flush
      push_byte(8'hF0, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'hA9, 1'b1);
      // run cut short; held byte flushed as a stray
      push_byte(8'hE2, 1'b0);
      push_byte(8'h82, 1'b1);
      // lone lead at run end
      push_byte(8'hC2, 1'b1);
      // highest code point, completed by the run end byte
      push_byte(8'hF7, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b1);

      target = byte_queue.size() + RandomBytes;
      while (byte_queue.size() < target) add_run();

      while (byte_queue.size() != 0 || pending_code_points.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && pending_code_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Request driver: valid holds until the request is taken
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.data_byte <= '0;
         req_chan.run_end <= 1'b0;
      end else begin
         if (req_chan.valid && !req_fired) begin
            // keep offering the same byte
         end else if (byte_queue.size() != 0 &&
                      ((requests_taken >= QuietFrom && requests_taken < QuietTo) ||
                       $urandom_range(0, 99) >= IdlePercent)) begin
            req_chan.valid <= 1'b1;
            req_chan.data_byte <= byte_queue[0].data_byte;
            req_chan.run_end <= byte_queue[0].run_end;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (holdoff_left != 0) begin
            rsp_chan.ready <= 1'b0;
            holdoff_left--;
         end else if (!holdoff_done && requests_taken >= HoldoffStart) begin
            rsp_chan.ready <= 1'b0;
            holdoff_left = HoldoffCycles - 1;
            holdoff_done = 1'b1;
         end else begin
            rsp_chan.ready <= (requests_taken >= QuietFrom && requests_taken < QuietTo) ||
                              ($urandom_range(0, 99) >= IdlePercent);
         end
      end
   end

   // Monitor: check responses, predict from accepted requests
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("tb: failure");
            $finish;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_code_points.size() == 0) begin
               $display("%0t: unexpected code point, expected none, got %h run_last %b",
                        $realtime, rsp_chan.code_point, rsp_chan.run_last);
               mismatches++;
            end else begin
               oldest = pending_code_points.pop_front();
               if (rsp_chan.code_point !== oldest.code_point) begin
                  $display("%0t: code_point expected %h, got %h",
                           $realtime, oldest.code_point, rsp_chan.code_point);
                  mismatches++;
               end
               if (rsp_chan.run_last !== oldest.run_last) begin
                  $display("%0t: run_last expected %b, got %b",
                           $realtime, oldest.run_last, rsp_chan.run_last);
                  mismatches++;
               end
            end
         end
         req_fired = req_chan.valid && req_chan.ready;
         if (req_fired) begin
            decode_request(byte_queue.pop_front());
            requests_taken++;
         end
      end
   end

endmodule
